FILE: rtl/rau_pkg.sv
// Shared types, codes and constants of the rational arithmetic unit.
package rau_pkg;

   localparam int unsigned ResWidth = 32;
   localparam logic [63:0] NumLimit = 64'(1) << (ResWidth - 1);

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_ZDEN = 2'd1;
   localparam logic [1:0] STAT_DIV0 = 2'd2;
   localparam logic [1:0] STAT_OVF  = 2'd3;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_SUM, ST_GCD, ST_DSTN, ST_WAITN,
      ST_DSTD, ST_WAITD, ST_CHK, ST_EMIT
   } state_type;

endpackage

FILE: rtl/rau_mul.sv
// Registered 32x32 unsigned multiplier shared by all product steps.
module rau_mul import rau_pkg::*; (
   input  logic        clock,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [63:0] p
);
   logic [63:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= 64'(a) * 64'(b);
   end

   assign p = p_ff;
endmodule

FILE: rtl/rau_div.sv
// Restoring 64-bit divider, one quotient bit per cycle.
module rau_div import rau_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] dsr_ff, dsr_in;
   logic [64:0] shifted;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      shifted = {rem_ff, quo_ff[63]};
      if (start) begin
         run_in = 1'b1;
         cnt_in = 7'd64;
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
      end else if (run_ff) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = 64'(shifted - {1'b0, dsr_ff});
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

FILE: rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: sequencer, gcd unit and result register.
//
// Usage: a request word carries an opcode (add, subtract, multiply, divide) and
// two signed fractions. One response word returns the reduced numerator, the
// positive reduced denominator and a status (ok, zero operand denominator,
// division by zero, overflow). Error responses carry 0/0; zero results are 0/1.
//
// Handshake: a word moves on an edge where valid is high and stall is low.
// req_stall is high from acceptance until the result is loaded into the
// response register; one request is processed at a time.
//
// Sequence: operand errors go straight to the response. Otherwise two products
// (three for add and subtract) on the shared 32x32 multiplier plus one sum step;
// a zero sum is emitted as 0/1, else binary gcd steps follow on one 64-bit
// subtract/compare, then two passes of the restoring divider, with the total time
// set mostly by the gcd loop and divider. A new request is taken once idle again.
//
// Reset: synchronous, clears the sequencer and the response valid.
// A stalled response holds; the next request may be taken while it waits,
// and its result waits in the sequencer until the response register frees.
module rational_arithmetic_unit import rau_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);
   state_type   state_ff, state_in;
   logic [1:0]  op_ff, op_in;
   logic [31:0] am_ff, am_in, ad_ff, ad_in, bm_ff, bm_in, bd_ff, bd_in;
   logic        s1_ff, s1_in, s2_ff, s2_in, sd_ff, sd_in, nneg_ff, nneg_in;
   logic [1:0]  step_ff, step_in;
   logic [63:0] t1_ff, t1_in, t2_ff, t2_in, num_ff, num_in, den_ff, den_in;
   logic [63:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [5:0]  k_ff, k_in;
   rsp_type     res_ff, res_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rvld_ff, rvld_in;

   logic [31:0] ma, mb;
   logic [63:0] prod;
   logic        div_start, div_done;
   logic [63:0] div_quo, div_dvd;
   logic        addsub;
   logic [31:0] mag_an, mag_ad, mag_bn, mag_bd;
   logic        sg_an, sg_ad, sg_bn, sg_bd;
   logic        num_ovf;

   rau_mul u_mul (.clock(clock), .a(ma), .b(mb), .p(prod));

   rau_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_dvd), .divisor(gx_ff), .done(div_done), .quotient(div_quo)
   );

   assign addsub = (op_ff == OP_ADD) || (op_ff == OP_SUB);
   assign sg_an  = req_word.a_num[31];
   assign sg_ad  = req_word.a_den[31];
   assign sg_bn  = req_word.b_num[31];
   assign sg_bd  = req_word.b_den[31];
   assign mag_an = sg_an ? 32'(-req_word.a_num) : req_word.a_num;
   assign mag_ad = sg_ad ? 32'(-req_word.a_den) : req_word.a_den;
   assign mag_bn = sg_bn ? 32'(-req_word.b_num) : req_word.b_num;
   assign mag_bd = sg_bd ? 32'(-req_word.b_den) : req_word.b_den;

   // multiplier operand select: term one, denominator, then term two
   always_comb begin
      unique case (step_ff)
         2'd0: begin
            ma = am_ff;
            mb = (op_ff == OP_MUL) ? bm_ff : bd_ff;
         end
         2'd1: begin
            ma = ad_ff;
            mb = (op_ff == OP_DIV) ? bm_ff : bd_ff;
         end
         default: begin
            ma = bm_ff;
            mb = ad_ff;
         end
      endcase
   end

   assign div_start = (state_ff == ST_DSTN) || (state_ff == ST_DSTD);
   assign div_dvd   = (state_ff == ST_DSTN) ? num_ff : den_ff;
   assign num_ovf   = nneg_ff ? (num_ff > NumLimit) : (num_ff > NumLimit - 64'd1);

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      am_in = am_ff; ad_in = ad_ff; bm_in = bm_ff; bd_in = bd_ff;
      s1_in = s1_ff; s2_in = s2_ff; sd_in = sd_ff; nneg_in = nneg_ff;
      step_in = step_ff;
      t1_in = t1_ff; t2_in = t2_ff; num_in = num_ff; den_in = den_ff;
      gx_in = gx_ff; gy_in = gy_ff; k_in = k_ff;
      res_in = res_ff;
      rsp_in = rsp_ff;
      rvld_in = rvld_ff;

      // drop the response once taken
      if (rvld_ff && !rsp_stall) rvld_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_word.op;
               am_in = mag_an; ad_in = mag_ad; bm_in = mag_bn; bd_in = mag_bd;
               s1_in = (req_word.op == OP_MUL) ? (sg_an ^ sg_bn) : (sg_an ^ sg_bd);
               s2_in = sg_bn ^ sg_ad ^ (req_word.op == OP_SUB);
               sd_in = (req_word.op == OP_DIV) ? (sg_ad ^ sg_bn) : (sg_ad ^ sg_bd);
               step_in = 2'd0;
               res_in = '{res_num: '0, res_den: '0, status: STAT_OK};
               if (mag_ad == '0 || mag_bd == '0) begin
                  res_in.status = STAT_ZDEN;
                  state_in = ST_EMIT;
               end else if (req_word.op == OP_DIV && mag_bn == '0) begin
                  res_in.status = STAT_DIV0;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd1) t1_in = prod;
            if (step_ff == 2'd2) begin
               den_in = prod;
               if (!addsub) state_in = ST_SUM;
            end
            if (step_ff == 2'd3) begin
               t2_in = prod;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (!addsub) begin
               num_in = t1_ff;
               nneg_in = s1_ff;
            end else if (s1_ff == s2_ff) begin
               num_in = t1_ff + t2_ff;
               nneg_in = s1_ff;
            end else if (t1_ff >= t2_ff) begin
               num_in = t1_ff - t2_ff;
               nneg_in = s1_ff;
            end else begin
               num_in = t2_ff - t1_ff;
               nneg_in = s2_ff;
            end
            // move the denominator sign onto the numerator
            nneg_in = nneg_in ^ sd_ff;
            gx_in = num_in;
            gy_in = den_ff;
            k_in = '0;
            if (num_in == '0) begin
               res_in = '{res_num: '0, res_den: 31'd1, status: STAT_OK};
               state_in = ST_EMIT;
            end else begin
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (!gx_ff[0] && !gy_ff[0]) begin
               gx_in = gx_ff >> 1;
               gy_in = gy_ff >> 1;
               k_in = k_ff + 6'd1;
            end else if (!gx_ff[0]) begin
               gx_in = gx_ff >> 1;
            end else if (!gy_ff[0]) begin
               gy_in = gy_ff >> 1;
            end else if (gx_ff == gy_ff) begin
               gx_in = gx_ff << k_ff;
               state_in = ST_DSTN;
            end else if (gx_ff > gy_ff) begin
               gx_in = gx_ff - gy_ff;
            end else begin
               gy_in = gy_ff - gx_ff;
            end
         end
         ST_DSTN: state_in = ST_WAITN;
         ST_WAITN: begin
            if (div_done) begin
               num_in = div_quo;
               state_in = ST_DSTD;
            end
         end
         ST_DSTD: state_in = ST_WAITD;
         ST_WAITD: begin
            if (div_done) begin
               den_in = div_quo;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (num_ovf || den_ff > NumLimit - 64'd1) begin
               res_in = '{res_num: '0, res_den: '0, status: STAT_OVF};
            end else begin
               res_in.res_num = nneg_ff ? 32'(32'd0 - num_ff[31:0]) : num_ff[31:0];
               res_in.res_den = den_ff[30:0];
               res_in.status = STAT_OK;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the response register is free
            if (!rvld_ff || !rsp_stall) begin
               rsp_in = res_ff;
               rvld_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rvld_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rvld_ff  <= rvld_in;
         step_ff  <= step_in;
      end
      op_ff <= op_in;
      am_ff <= am_in; ad_ff <= ad_in; bm_ff <= bm_in; bd_ff <= bd_in;
      s1_ff <= s1_in; s2_ff <= s2_in; sd_ff <= sd_in; nneg_ff <= nneg_in;
      t1_ff <= t1_in; t2_ff <= t2_in; num_ff <= num_in; den_ff <= den_in;
      gx_ff <= gx_in; gy_ff <= gy_in; k_ff <= k_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rvld_ff;
   assign rsp_word  = rsp_ff;
endmodule

FILE: rtl/rau_chk.sv
// Port-level checks of the rational arithmetic unit and their binding.
module rau_chk import rau_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_word,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_word
);
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_word))
      else $error("stalled request word changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled response word changed");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != STAT_OK |->
         rsp_word.res_num == '0 && rsp_word.res_den == '0)
      else $error("error response carries a nonzero fraction");

   a_ok_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == STAT_OK |-> rsp_word.res_den != '0)
      else $error("ok response with zero denominator");

   a_zero_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == STAT_OK && rsp_word.res_num == '0 |->
         rsp_word.res_den == 31'd1)
      else $error("zero result not reported as 0/1");
endmodule

bind rational_arithmetic_unit rau_chk u_rau_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_word(req_word), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_word(rsp_word)
);
